>>> src/stp_pkg.sv
// shared types, widths and constants of the steering torque pi controller
package stp_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);

    localparam int ANG_W   = 15;
    localparam int GAIN_W  = 10;
    localparam int MAG_W   = 14;
    localparam int KI_W    = 16;
    localparam int LIM_W   = 15;
    localparam int CNT_W   = 7;
    localparam int CMD_W   = 16;
    localparam int TRAD_W  = 17;
    localparam int ENTRY_W = ANG_W + GAIN_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_KI_POSITIVE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KI_MIDDLE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KI_FAR       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KI_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TORQUE_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_COUNT  = 3'd5;

    // radians per 1/16 degree in q.36
    localparam logic [26:0] RAD_K = 27'd74961320;

    // divider: magnitude of gain step times angle step over angle span
    localparam int DIV_N_W   = 25;
    localparam int DIV_D_W   = 16;
    localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

    typedef struct packed {
        logic [ANG_W-1:0]  angle;
        logic [GAIN_W-1:0] gain;
    } stp_entry_t;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } stp_div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_N_W-1:0] quotient;
    } stp_div_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MT,
        ST_MM,
        ST_ERR,
        ST_FETCH,
        ST_CMP,
        ST_IMUL,
        ST_DSTART,
        ST_DIV,
        ST_PMUL,
        ST_KMUL,
        ST_OUT
    } stp_state_t;

endpackage

>>> src/stp_chan_if.sv
// valid/ready channel interfaces for step items and result items
interface stp_in_if;
    import stp_pkg::*;
    logic                valid;
    logic                ready;
    logic                mode;
    logic [5:0]          entry_index;
    logic [ANG_W-1:0]    entry_angle;
    logic [GAIN_W-1:0]   entry_gain;
    logic [MAG_W-1:0]    target_magnitude;
    logic                target_direction;
    logic [MAG_W-1:0]    measured_magnitude;
    logic                measured_direction;

    modport source (
        output valid, mode, entry_index, entry_angle, entry_gain,
               target_magnitude, target_direction, measured_magnitude, measured_direction,
        input  ready
    );
    modport sink (
        input  valid, mode, entry_index, entry_angle, entry_gain,
               target_magnitude, target_direction, measured_magnitude, measured_direction,
        output ready
    );
endinterface

interface stp_out_if;
    import stp_pkg::*;
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    torque_command;
    logic                torque_clamped;
    logic [GAIN_W-1:0]   gain_used;
    logic [TRAD_W-1:0]   target_radians;

    modport source (
        output valid, torque_command, torque_clamped, gain_used, target_radians,
        input  ready
    );
    modport sink (
        input  valid, torque_command, torque_clamped, gain_used, target_radians,
        output ready
    );
endinterface

>>> src/steer_torque_pi_gain_scheduled_top.sv
// top level of the gain scheduled pi steering torque controller
// A load item (mode 0) writes one breakpoint of the gain table in the cycle it is
// transferred and leaves the block ready at once. A step item (mode 1) converts the
// target and measured angles to radians, updates the saturating error integral, walks
// the gain table for the proportional gain, and forms the clamped torque; it yields one
// result. All products go through one shared 18x33 signed multiplier under a sequencer.
// The table walk reads one breakpoint at a time through the table ram's single read
// port, in a fetch state and a compare state. A step is shortest when the target is
// below the first breakpoint, walks the table to its last breakpoint in use when no
// segment holds it (n breakpoints in use, 2..64), and when it falls in segment k it
// adds the interpolation multiply, the divider start and the wait on the divider (one
// quotient bit per cycle). The block is not ready while a step is in work; it takes
// the next item from the cycle after the result register loads. A result that cannot
// leave holds the sequencer in its last state for as long as the older result still
// waits; a finished result waits in the output register, and the next item is taken
// meanwhile.
module steer_torque_pi_gain_scheduled_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [stp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [stp_pkg::CFG_DATA_W-1:0] cfg_data,
    stp_in_if.sink                         step_chan,
    stp_out_if.source                      result_chan
);
    import stp_pkg::*;

    // configuration registers
    logic [KI_W-1:0]         ki_pos_reg;
    logic [KI_W-1:0]         ki_mid_reg;
    logic [KI_W-1:0]         ki_far_reg;
    logic signed [ANG_W-1:0] thr_reg;
    logic [LIM_W-1:0]        lim_reg;
    logic [CNT_W-1:0]        entries_reg;

    // sequencer
    stp_state_t state_reg;
    stp_state_t state_next;

    // step item working values
    logic [MAG_W-1:0]        tmag_reg;
    logic                    tdir_reg;
    logic [MAG_W-1:0]        mmag_reg;
    logic                    mdir_reg;
    logic signed [ANG_W-1:0] t_reg;
    logic signed [50:0]      prod_reg;
    logic signed [25:0]      rt_reg;
    logic [TRAD_W-1:0]       trad_reg;
    logic signed [26:0]      err_reg;
    logic signed [31:0]      integral_reg;
    logic [IDX_W-1:0]        idx_reg;
    stp_entry_t              prev_reg;
    stp_entry_t              cur_reg;
    logic [GAIN_W-1:0]       kp_reg;
    logic signed [51:0]      acc_reg;

    // output register
    logic                    res_valid_reg;
    logic [CMD_W-1:0]        cmd_reg;
    logic                    clamp_reg;
    logic [GAIN_W-1:0]       gain_reg;
    logic [TRAD_W-1:0]       trad_out_reg;

    // transfers
    logic xfer_in;
    logic load_xfer;
    logic step_xfer;
    logic out_free;

    // shared multiplier
    logic signed [17:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [50:0] mul_prod;

    // table ram
    stp_entry_t       ram_wdata;
    stp_entry_t       ram_rdata;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;

    // divider
    stp_div_req_t div_req;
    stp_div_rsp_t div_rsp;

    // combinational helpers
    logic [8:0]              n_last;
    logic [IDX_W-1:0]        last_idx;
    logic signed [ANG_W-1:0] t_in;
    logic [40:0]             rnd16;
    logic [40:0]             rnd24;
    logic [24:0]             conv_mag;
    logic [16:0]             tq12;
    logic signed [25:0]      rm_val;
    logic signed [26:0]      err_val;
    logic signed [32:0]      isum;
    logic signed [ANG_W-1:0] rd_angle;
    logic signed [ANG_W-1:0] prev_angle;
    logic signed [ANG_W-1:0] cur_angle;
    logic                    in_seg;
    logic signed [10:0]      gdiff;
    logic signed [15:0]      tdiff;
    logic signed [15:0]      span;
    logic [50:0]             prod_mag;
    logic [11:0]             kp_sum;
    logic [KI_W-1:0]         ki_sel;
    logic [51:0]             acc_mag;
    logic [51:0]             acc_rnd;
    logic [27:0]             raw_mag;
    logic                    over;
    logic [CMD_W-1:0]        mag_out;

    assign xfer_in   = step_chan.valid && step_chan.ready;
    assign load_xfer = xfer_in && !step_chan.mode;
    assign step_xfer = xfer_in && step_chan.mode;
    assign out_free  = !res_valid_reg || result_chan.ready;

    assign step_chan.ready = (state_reg == ST_IDLE);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ki_pos_reg  <= KI_W'(328);
            ki_mid_reg  <= KI_W'(393);
            ki_far_reg  <= KI_W'(197);
            thr_reg     <= -ANG_W'(5760);
            lim_reg     <= LIM_W'(12288);
            entries_reg <= CNT_W'(44);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_KI_POSITIVE:  ki_pos_reg  <= cfg_data[KI_W-1:0];
                CFG_KI_MIDDLE:    ki_mid_reg  <= cfg_data[KI_W-1:0];
                CFG_KI_FAR:       ki_far_reg  <= cfg_data[KI_W-1:0];
                CFG_KI_THRESHOLD: thr_reg     <= $signed(cfg_data[ANG_W-1:0]);
                CFG_TORQUE_LIMIT: lim_reg     <= cfg_data[LIM_W-1:0];
                CFG_TABLE_COUNT:  entries_reg <= cfg_data[CNT_W-1:0];
                default:          ;
            endcase
        end
    end

    // breakpoint table, written straight from a load transfer
    assign ram_we          = load_xfer && (32'(step_chan.entry_index) < TABLE_DEPTH);
    assign ram_waddr       = IDX_W'(step_chan.entry_index);
    assign ram_wdata.angle = step_chan.entry_angle;
    assign ram_wdata.gain  = step_chan.entry_gain;

    stp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // last breakpoint in use, entry count held to 2..depth
    always_comb
    begin
        if (entries_reg < CNT_W'(2))
        begin
            n_last = 9'd1;
        end
        else if (9'(entries_reg) > 9'(TABLE_DEPTH))
        begin
            n_last = 9'(TABLE_DEPTH - 1);
        end
        else
        begin
            n_last = 9'(entries_reg) - 9'd1;
        end
    end
    assign last_idx = n_last[IDX_W-1:0];

    assign t_in = step_chan.target_direction ?
                  -$signed({1'b0, step_chan.target_magnitude}) :
                  $signed({1'b0, step_chan.target_magnitude});

    // radians conversion, half away from zero on the magnitude
    assign rnd16    = prod_reg[40:0] + 41'd32768;
    assign rnd24    = prod_reg[40:0] + 41'd8388608;
    assign conv_mag = rnd16[40:16];
    assign tq12     = rnd24[40:24];
    assign rm_val   = mdir_reg ? -$signed({1'b0, conv_mag}) : $signed({1'b0, conv_mag});
    assign err_val  = 27'(rt_reg) - 27'(rm_val);
    assign isum     = 33'(integral_reg) + 33'(err_reg);

    // table walk compare
    assign rd_angle   = $signed(ram_rdata.angle);
    assign prev_angle = $signed(prev_reg.angle);
    assign cur_angle  = $signed(cur_reg.angle);
    assign in_seg     = (t_reg >= prev_angle) && (t_reg < rd_angle);

    // interpolation operands
    assign gdiff    = $signed({1'b0, cur_reg.gain}) - $signed({1'b0, prev_reg.gain});
    assign tdiff    = 16'(t_reg) - 16'(prev_angle);
    assign span     = 16'(cur_angle) - 16'(prev_angle);
    assign prod_mag = prod_reg[50] ? 51'(-prod_reg) : 51'(prod_reg);
    assign kp_sum   = prod_reg[50] ?
                      {2'b00, prev_reg.gain} - {1'b0, div_rsp.quotient[10:0]} :
                      {2'b00, prev_reg.gain} + {1'b0, div_rsp.quotient[10:0]};

    // integral gain band on the target angle
    always_comb
    begin
        if (t_reg >= 0)
        begin
            ki_sel = ki_pos_reg;
        end
        else if (t_reg > thr_reg)
        begin
            ki_sel = ki_mid_reg;
        end
        else
        begin
            ki_sel = ki_far_reg;
        end
    end

    // final rounding to q4.12 and clamp
    assign acc_mag = acc_reg[51] ? 52'(-acc_reg) : 52'(acc_reg);
    assign acc_rnd = acc_mag + 52'd8388608;
    assign raw_mag = acc_rnd[51:24];
    assign over    = raw_mag > 28'(lim_reg);
    assign mag_out = over ? 16'(lim_reg) : raw_mag[CMD_W-1:0];

    // shared multiplier operand select
    always_comb
    begin
        case (state_reg)
            ST_MT:
            begin
                mul_a = $signed({4'b0, tmag_reg});
                mul_b = $signed({6'b0, RAD_K});
            end
            ST_MM:
            begin
                mul_a = $signed({4'b0, mmag_reg});
                mul_b = $signed({6'b0, RAD_K});
            end
            ST_IMUL:
            begin
                mul_a = 18'(gdiff);
                mul_b = 33'(tdiff);
            end
            ST_PMUL:
            begin
                mul_a = $signed({8'b0, kp_reg});
                mul_b = 33'(err_reg);
            end
            ST_KMUL:
            begin
                mul_a = $signed({2'b0, ki_sel});
                mul_b = 33'(integral_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_prod = 51'(mul_a) * 51'(mul_b);

    assign div_req.start    = (state_reg == ST_DSTART);
    assign div_req.dividend = prod_mag[DIV_N_W-1:0];
    assign div_req.divisor  = span;

    stp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (step_xfer)
                begin
                    state_next = ST_MT;
                end
            end
            ST_MT:     state_next = ST_MM;
            ST_MM:     state_next = ST_ERR;
            ST_ERR:    state_next = ST_FETCH;
            ST_FETCH:  state_next = ST_CMP;
            ST_CMP:
            begin
                if (idx_reg == '0)
                begin
                    state_next = (t_reg < rd_angle) ? ST_PMUL : ST_FETCH;
                end
                else if (in_seg)
                begin
                    state_next = ST_IMUL;
                end
                else if (idx_reg == last_idx)
                begin
                    state_next = ST_PMUL;
                end
                else
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_IMUL:   state_next = ST_DSTART;
            ST_DSTART: state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_PMUL;
                end
            end
            ST_PMUL:   state_next = ST_KMUL;
            ST_KMUL:   state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // error integral, saturating at the int32 bounds
    // updated from the registered error once per step, ahead of the ki product
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_reg <= '0;
        end
        else if (state_reg == ST_PMUL)
        begin
            if (isum > 33'sh0_7FFF_FFFF)
            begin
                integral_reg <= 32'sh7FFF_FFFF;
            end
            else if (isum < -33'sh0_8000_0000)
            begin
                integral_reg <= 32'sh8000_0000;
            end
            else
            begin
                integral_reg <= isum[31:0];
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (step_xfer)
                begin
                    tmag_reg <= step_chan.target_magnitude;
                    tdir_reg <= step_chan.target_direction;
                    mmag_reg <= step_chan.measured_magnitude;
                    mdir_reg <= step_chan.measured_direction;
                    t_reg    <= t_in;
                end
            end
            ST_MT:
            begin
                prod_reg <= mul_prod;
            end
            ST_MM:
            begin
                prod_reg <= mul_prod;
                rt_reg   <= tdir_reg ? -$signed({1'b0, conv_mag}) : $signed({1'b0, conv_mag});
                if (tdir_reg)
                begin
                    trad_reg <= (tq12 > 17'd65536) ? 17'h10000 : 17'(-tq12);
                end
                else
                begin
                    trad_reg <= (tq12 > 17'd65535) ? 17'h0FFFF : tq12;
                end
            end
            ST_ERR:
            begin
                err_reg <= err_val;
                idx_reg <= '0;
            end
            ST_CMP:
            begin
                if (idx_reg == '0)
                begin
                    if (t_reg < rd_angle)
                    begin
                        kp_reg <= ram_rdata.gain;
                    end
                    else
                    begin
                        prev_reg <= ram_rdata;
                        idx_reg  <= idx_reg + 1'b1;
                    end
                end
                else if (in_seg)
                begin
                    cur_reg <= ram_rdata;
                end
                else if (idx_reg == last_idx)
                begin
                    kp_reg <= ram_rdata.gain;
                end
                else
                begin
                    prev_reg <= ram_rdata;
                    idx_reg  <= idx_reg + 1'b1;
                end
            end
            ST_IMUL:
            begin
                prod_reg <= mul_prod;
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    kp_reg <= kp_sum[GAIN_W-1:0];
                end
            end
            ST_PMUL:
            begin
                prod_reg <= mul_prod;
            end
            ST_KMUL:
            begin
                // proportional term is q.28, moved up to q.36
                acc_reg <= (52'(prod_reg) <<< 8) + 52'(mul_prod);
            end
            default:
            begin
            end
        endcase
    end

    // result register, loaded when the slot is free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_OUT && out_free)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result_chan.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT && out_free)
        begin
            cmd_reg      <= acc_reg[51] ? -mag_out : mag_out;
            clamp_reg    <= over;
            gain_reg     <= kp_reg;
            trad_out_reg <= trad_reg;
        end
    end

    assign result_chan.valid          = res_valid_reg;
    assign result_chan.torque_command = cmd_reg;
    assign result_chan.torque_clamped = clamp_reg;
    assign result_chan.gain_used      = gain_reg;
    assign result_chan.target_radians = trad_out_reg;

    // a step transfer always starts the conversion sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        step_xfer |=> state_reg == ST_MT)
    else $error("step transfer did not start the sequence");

    // a load transfer leaves the block idle
    assert property (@(posedge clk) disable iff (!rst_n)
        load_xfer |=> state_reg == ST_IDLE)
    else $error("load transfer left the idle state");

    // integral moves only in the error update step
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_PMUL |=> $stable(integral_reg))
    else $error("error integral changed outside the update step");

    // divider finishes only while the sequencer waits on it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == ST_DIV)
    else $error("divider done outside the wait state");

endmodule

>>> src/stp_ram.sv
// generic single write port ram with registered read
module stp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/stp_div.sv
// restoring divider, one quotient bit per cycle
module stp_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  stp_pkg::stp_div_req_t req,
    output stp_pkg::stp_div_rsp_t rsp
);
    import stp_pkg::*;

    logic [DIV_D_W-1:0]   rem_reg;
    logic [DIV_N_W-1:0]   quo_reg;
    logic [DIV_D_W-1:0]   den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DIV_D_W:0]     trial;
    logic                 fits;
    logic [DIV_D_W:0]     diff;

    assign trial = {rem_reg, quo_reg[DIV_N_W-1]};
    assign fits  = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_N_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            den_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
            quo_reg <= {quo_reg[DIV_N_W-2:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

>>> sim/stp_torque_checker.sv
// checker that predicts and compares torque results of the steering pi controller
module stp_torque_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [stp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [stp_pkg::CFG_DATA_W-1:0] cfg_data,
    stp_in_if                              step_mon,
    stp_out_if                             result_mon,
    output int                             mismatches,
    output int                             outstanding
);
    import stp_pkg::*;

    typedef struct {
        logic [CMD_W-1:0]  torque_command;
        logic              torque_clamped;
        logic [GAIN_W-1:0] gain_used;
        logic [TRAD_W-1:0] target_radians;
    } torque_result_t;

    torque_result_t         torque_due_q[$];
    torque_result_t         want;

    logic [KI_W-1:0]        ki_pos;
    logic [KI_W-1:0]        ki_mid;
    logic [KI_W-1:0]        ki_far;
    logic signed [ANG_W-1:0] ki_thr;
    logic [LIM_W-1:0]       limit;
    logic [CNT_W-1:0]       entry_count;
    longint                 bp_angle [TABLE_DEPTH];
    longint                 bp_gain [TABLE_DEPTH];
    longint                 err_sum;

    function automatic longint round_half(longint s, int sh);
        longint mag;
        longint r;
        mag = (s < 0) ? -s : s;
        r = (mag + (longint'(1) <<< (sh - 1))) >>> sh;
        return (s < 0) ? -r : r;
    endfunction

    function automatic longint scheduled_kp(longint t);
        int n;
        n = entry_count;
        if (n < 2) n = 2;
        if (n > TABLE_DEPTH) n = TABLE_DEPTH;
        if (t < bp_angle[0])
            return bp_gain[0];
        for (int i = 0; i + 1 < n; i++)
        begin
            if (t >= bp_angle[i] && t < bp_angle[i+1])
                return bp_gain[i] + ((bp_gain[i+1] - bp_gain[i]) * (t - bp_angle[i]))
                       / (bp_angle[i+1] - bp_angle[i]);
        end
        return bp_gain[n-1];
    endfunction

    // one control step: updates the error integral and returns the torque result
    function automatic torque_result_t control_step(logic [MAG_W-1:0] tm, logic td,
                                                    logic [MAG_W-1:0] mm, logic md);
        torque_result_t r;
        longint k, t, m, rt, rm, err, kp, ki, raw, cmd, tq;
        k = longint'(RAD_K);
        t = td ? -longint'(tm) : longint'(tm);
        m = md ? -longint'(mm) : longint'(mm);
        rt = round_half(t * k, 16);
        rm = round_half(m * k, 16);
        err = rt - rm;
        err_sum = err_sum + err;
        if (err_sum > 64'sd2147483647) err_sum = 64'sd2147483647;
        if (err_sum < -64'sd2147483648) err_sum = -64'sd2147483648;
        kp = scheduled_kp(t);
        if (t >= 0)
            ki = ki_pos;
        else if (t > longint'(ki_thr))
            ki = ki_mid;
        else
            ki = ki_far;
        raw = round_half(kp * err * 256 + ki * err_sum, 24);
        cmd = raw;
        r.torque_clamped = 1'b0;
        if (raw > longint'(limit))
        begin
            cmd = limit;
            r.torque_clamped = 1'b1;
        end
        else if (raw < -longint'(limit))
        begin
            cmd = -longint'(limit);
            r.torque_clamped = 1'b1;
        end
        tq = (longint'(tm) * k + (longint'(1) <<< 23)) >>> 24;
        if (td)
            tq = (tq > 65536) ? -65536 : -tq;
        else if (tq > 65535)
            tq = 65535;
        r.torque_command = cmd[CMD_W-1:0];
        r.gain_used      = kp[GAIN_W-1:0];
        r.target_radians = tq[TRAD_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ki_pos      = 16'd328;
            ki_mid      = 16'd393;
            ki_far      = 16'd197;
            ki_thr      = -15'sd5760;
            limit       = 15'd12288;
            entry_count = 7'd44;
            err_sum     = 0;
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                bp_angle[i] = 0;
                bp_gain[i]  = 0;
            end
            torque_due_q.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_KI_POSITIVE:  ki_pos      = cfg_data[KI_W-1:0];
                    CFG_KI_MIDDLE:    ki_mid      = cfg_data[KI_W-1:0];
                    CFG_KI_FAR:       ki_far      = cfg_data[KI_W-1:0];
                    CFG_KI_THRESHOLD: ki_thr      = cfg_data[ANG_W-1:0];
                    CFG_TORQUE_LIMIT: limit       = cfg_data[LIM_W-1:0];
                    CFG_TABLE_COUNT:  entry_count = cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
            // results always belong to earlier steps, so compare before predicting
            if (result_mon.valid && result_mon.ready)
            begin
                if (torque_due_q.size() == 0)
                begin
                    $error("result transfer with no step pending");
                    mismatches++;
                end
                else
                begin
                    want = torque_due_q.pop_front();
                    if (result_mon.torque_command !== want.torque_command)
                    begin
                        $error("torque_command expected %0d got %0d",
                               $signed(want.torque_command),
                               $signed(result_mon.torque_command));
                        mismatches++;
                    end
                    if (result_mon.torque_clamped !== want.torque_clamped)
                    begin
                        $error("torque_clamped expected %0d got %0d",
                               want.torque_clamped, result_mon.torque_clamped);
                        mismatches++;
                    end
                    if (result_mon.gain_used !== want.gain_used)
                    begin
                        $error("gain_used expected %0d got %0d",
                               want.gain_used, result_mon.gain_used);
                        mismatches++;
                    end
                    if (result_mon.target_radians !== want.target_radians)
                    begin
                        $error("target_radians expected %0d got %0d",
                               $signed(want.target_radians),
                               $signed(result_mon.target_radians));
                        mismatches++;
                    end
                end
            end
            if (step_mon.valid && step_mon.ready)
            begin
                if (!step_mon.mode)
                begin
                    bp_angle[step_mon.entry_index] = longint'($signed(step_mon.entry_angle));
                    bp_gain[step_mon.entry_index]  = longint'(step_mon.entry_gain);
                end
                else
                    torque_due_q.push_back(control_step(step_mon.target_magnitude,
                        step_mon.target_direction, step_mon.measured_magnitude,
                        step_mon.measured_direction));
            end
            outstanding = torque_due_q.size();
        end
    end

endmodule

>>> sim/tb.sv
// testbench top: stimulus, configuration phases and verdict for the steering pi controller
module tb;
    import stp_pkg::*;

    // cycles with no transfer on either channel before the run is declared hung
    localparam int IDLE_LIMIT = 20000;
    // quiet cycles after the last result before a register write or the verdict
    localparam int SETTLE_CYCLES = 300;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    mismatches;
    int                    outstanding;
    int                    idle_cycles;
    int                    table_angle [TABLE_DEPTH];

    stp_in_if  step_chan ();
    stp_out_if result_chan ();

    steer_torque_pi_gain_scheduled_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .step_chan   (step_chan),
        .result_chan (result_chan)
    );

    stp_torque_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .step_mon    (step_chan),
        .result_mon  (result_chan),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // hang detection: any transfer restarts the count
    always @(posedge clk)
    begin
        if ((step_chan.valid && step_chan.ready) || (result_chan.valid && result_chan.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[steer_torque_pi_gain_scheduled_top] ERROR");
            $finish;
        end
    end

    // result side back-pressure with random stalls
    initial
    begin
        int stall;
        result_chan.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = pick_gap();
            if (stall > 0)
            begin
                result_chan.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_chan.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    // one transfer on the step channel; entered and left at a rising edge
    task automatic send_item(logic m, logic [5:0] idx, logic [ANG_W-1:0] ang,
                             logic [GAIN_W-1:0] gn, logic [MAG_W-1:0] tm, logic td,
                             logic [MAG_W-1:0] mm, logic md);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            step_chan.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        step_chan.valid              <= 1'b1;
        step_chan.mode               <= m;
        step_chan.entry_index        <= idx;
        step_chan.entry_angle        <= ang;
        step_chan.entry_gain         <= gn;
        step_chan.target_magnitude   <= tm;
        step_chan.target_direction   <= td;
        step_chan.measured_magnitude <= mm;
        step_chan.measured_direction <= md;
        // ready is stable at the falling edge, so this is the transfer edge
        @(negedge clk);
        while (!step_chan.ready) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic load_entry(int idx, int ang, int gn);
        table_angle[idx] = ang;
        send_item(1'b0, idx[5:0], ang[ANG_W-1:0], gn[GAIN_W-1:0], MAG_W'($urandom),
                  1'($urandom), MAG_W'($urandom), 1'($urandom));
    endtask

    task automatic send_step(int tm, int td, int mm, int md);
        send_item(1'b1, 6'($urandom), ANG_W'($urandom), GAIN_W'($urandom), tm[MAG_W-1:0],
                  td[0], mm[MAG_W-1:0], md[0]);
    endtask

    // step whose target sits on a signed angle in 1/16 degree
    task automatic step_at(int ang);
        send_step((ang < 0) ? -ang : ang, (ang < 0) ? 1 : 0, $urandom_range(0, 16383),
                  $urandom_range(0, 1));
    endtask

    // whole table: ascending breakpoints, or unordered noise
    task automatic load_table(bit ascending);
        int a;
        a = -11520 + $urandom_range(0, 3000);
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (ascending)
            begin
                load_entry(i, a, $urandom_range(0, 1023));
                a = a + $urandom_range(1, 400);
                if (a > 11520) a = 11520;
            end
            else
                load_entry(i, $signed(15'($urandom)), $urandom_range(0, 1023));
        end
    endtask

    task automatic random_step();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            step_at(table_angle[$urandom_range(0, TABLE_DEPTH - 1)] + $urandom_range(0, 2) - 1);
        else if (r < 8)
            send_step($urandom_range(0, 11520), $urandom_range(0, 1),
                      $urandom_range(0, 11520), $urandom_range(0, 1));
        else
            send_step($urandom_range(0, 16383), $urandom_range(0, 1),
                      $urandom_range(0, 16383), $urandom_range(0, 1));
    endtask

    task automatic random_phase(int items);
        int r;
        int n;
        n = 0;
        while (n < items)
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
            begin
                load_table($urandom_range(0, 4) != 0);
                n += TABLE_DEPTH;
            end
            else if (r < 10)
            begin
                load_entry($urandom_range(0, TABLE_DEPTH - 1), $signed(15'($urandom)),
                           $urandom_range(0, 1023));
                n++;
            end
            else if (r < 12)
            begin
                // long run of full-scale error to drive the integral into saturation
                r = $urandom_range(0, 1);
                repeat (70) send_step(16383, r, 16383, 1 - r);
                n += 70;
            end
            else
            begin
                random_step();
                n++;
            end
        end
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data[CFG_DATA_W-1:0];
        @(posedge clk);
    endtask

    // registers change only with the block idle and every result in
    task automatic settle();
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(int kp, int km, int kf, int thr, int lim, int cnt);
        // no new transfer while the block drains
        step_chan.valid <= 1'b0;
        settle();
        cfg_write(CFG_KI_POSITIVE, kp);
        cfg_write(CFG_KI_MIDDLE, km);
        cfg_write(CFG_KI_FAR, kf);
        cfg_write(CFG_KI_THRESHOLD, thr);
        cfg_write(CFG_TORQUE_LIMIT, lim);
        cfg_write(CFG_TABLE_COUNT, cnt);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        rst_n                        <= 1'b0;
        cfg_wr_en                    <= 1'b0;
        cfg_index                    <= '0;
        cfg_data                     <= '0;
        step_chan.valid              <= 1'b0;
        step_chan.mode               <= 1'b0;
        step_chan.entry_index        <= '0;
        step_chan.entry_angle        <= '0;
        step_chan.entry_gain         <= '0;
        step_chan.target_magnitude   <= '0;
        step_chan.target_direction   <= 1'b0;
        step_chan.measured_magnitude <= '0;
        step_chan.measured_direction <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values; every entry is written before any step reads it
        load_table(1'b1);
        send_step(0, 0, 0, 0);
        send_step(11520, 0, 11520, 1);
        send_step(11520, 1, 11520, 0);
        send_step(16383, 0, 16383, 1);
        send_step(16383, 1, 0, 0);
        send_step(0, 1, 16383, 1);
        step_at(table_angle[0] - 1);
        step_at(table_angle[0]);
        step_at(table_angle[1] - 1);
        step_at(table_angle[43]);
        step_at(table_angle[43] + 1);
        step_at(-5760);
        step_at(-5761);
        step_at(-5759);
        random_phase(150);

        // extremes: largest gains and limit, middle band at its widest
        configure(65535, 65535, 65535, -11520, 32767, 64);
        repeat (70) send_step(16383, 0, 16383, 1);
        repeat (70) send_step(16383, 1, 16383, 0);
        step_at(table_angle[63]);
        step_at(11520);
        random_phase(200);

        // zero gains and limit, smallest table, no middle band
        configure(0, 0, 0, 0, 0, 2);
        step_at(0);
        step_at(-1);
        random_phase(200);

        // entry counts beyond range saturate at both ends
        configure($urandom_range(0, 65535), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), -$urandom_range(0, 11520), 32767, 127);
        random_phase(200);
        configure($urandom_range(0, 65535), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), -$urandom_range(0, 11520), 1, 0);
        random_phase(200);

        repeat (4)
        begin
            configure($urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 65535), -$urandom_range(0, 11520),
                      $urandom_range(0, 32767), $urandom_range(0, 127));
            random_phase(250);
        end

        step_chan.valid <= 1'b0;
        settle();
        if (mismatches == 0)
            $display("[steer_torque_pi_gain_scheduled_top] OK");
        else
            $display("[steer_torque_pi_gain_scheduled_top] ERROR");
        $finish;
    end

endmodule
